// ----- rtl/core/cpba_pkg.sv -----
// cpba_pkg: shared constants, controller states and scan unit control and result structs
// for the contiguous page bitmap allocator
// no dependencies
`default_nettype none

package cpba_pkg;

    // bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // field widths
    localparam int FP_W      = 12;  // first_page, free_start, run_start
    localparam int CNT_W     = 13;  // page_count, page_limit, run length
    localparam int PAGE_W    = 14;  // internal page numbers, room for start + count
    localparam int WIDX_W    = 8;   // word index of any page below 8192
    localparam int ISS_W     = 9;   // word counter, one past the last word
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;   // restart the free-run counter
        logic step;    // a word is being evaluated this cycle
    } scan_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] start;
    } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpba_ram.sv -----
// cpba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cpba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire                       re,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpba_scan.sv -----
// cpba_scan: first-fit evaluation of one bitmap word with the free-run carry
// depends on cpba_pkg
`default_nettype none

module cpba_scan (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire  cpba_pkg::scan_ctl_t       ctl,
    input  wire  [cpba_pkg::WORD_BITS-1:0]  rdata,
    input  wire  [cpba_pkg::WIDX_W-1:0]     word,
    input  wire  [cpba_pkg::FP_W-1:0]       first_page,
    input  wire  [cpba_pkg::CNT_W-1:0]      lim,
    input  wire  [cpba_pkg::CNT_W-1:0]      count,
    output cpba_pkg::scan_res_t             res
);

    logic [cpba_pkg::CNT_W-1:0]     run_reg;
    logic [cpba_pkg::CNT_W-1:0]     run_next;
    logic [cpba_pkg::WORD_BITS-1:0] used_eff;
    logic [cpba_pkg::WORD_BITS-1:0] anyu;
    logic [cpba_pkg::WORD_BITS-1:0] hit;
    logic [cpba_pkg::BIT_W-1:0]     lastu [cpba_pkg::WORD_BITS];
    logic [cpba_pkg::BIT_W-1:0]     hit_idx;
    logic                           found;
    logic [cpba_pkg::CNT_W-1:0]     pg;

    // pages outside [first_page, lim) count as used
    always_comb
    begin
        for (int i = 0; i < cpba_pkg::WORD_BITS; i++)
        begin
            pg = {word, cpba_pkg::BIT_W'(i)};
            used_eff[i] = rdata[i] || (pg < {1'b0, first_page}) || (pg >= lim);
        end
    end

    // last used bit at or below each position
    always_comb
    begin
        for (int i = 0; i < cpba_pkg::WORD_BITS; i++)
        begin
            anyu[i]  = 1'b0;
            lastu[i] = '0;
            for (int j = 0; j < cpba_pkg::WORD_BITS; j++)
            begin
                if (j <= i && used_eff[j])
                begin
                    anyu[i]  = 1'b1;
                    lastu[i] = cpba_pkg::BIT_W'(j);
                end
            end
        end
    end

    // run ending at bit i reaches count
    always_comb
    begin
        for (int i = 0; i < cpba_pkg::WORD_BITS; i++)
        begin
            if (used_eff[i])
            begin
                hit[i] = 1'b0;
            end
            else if (anyu[i])
            begin
                hit[i] = (cpba_pkg::PAGE_W'(i) - cpba_pkg::PAGE_W'(lastu[i]))
                         >= {1'b0, count};
            end
            else
            begin
                hit[i] = ({1'b0, run_reg} + cpba_pkg::PAGE_W'(i) + 14'd1)
                         >= {1'b0, count};
            end
        end
    end

    // lowest hit wins
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = cpba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found   = 1'b1;
                hit_idx = cpba_pkg::BIT_W'(i);
            end
        end
        res.hit   = found;
        res.start = {1'b0, word, hit_idx} + 14'd1 - {1'b0, count};
        run_next  = anyu[cpba_pkg::WORD_BITS-1]
                  ? cpba_pkg::CNT_W'(5'd31 - lastu[cpba_pkg::WORD_BITS-1])
                  : run_reg + 13'd32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else if (ctl.clear)
        begin
            run_reg <= '0;
        end
        else if (ctl.step)
        begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpba_mark.sv -----
// cpba_mark: sets or clears the bits of one bitmap word that fall in a page range
// depends on cpba_pkg
`default_nettype none

module cpba_mark (
    input  wire  [cpba_pkg::WORD_BITS-1:0]  rdata,
    input  wire  [cpba_pkg::WIDX_W-1:0]     word,
    input  wire  [cpba_pkg::PAGE_W-1:0]     range_start,
    input  wire  [cpba_pkg::PAGE_W-1:0]     range_end,
    input  wire                             set,
    output logic [cpba_pkg::WORD_BITS-1:0]  wdata
);

    logic [cpba_pkg::PAGE_W-1:0] pg;

    always_comb
    begin
        for (int i = 0; i < cpba_pkg::WORD_BITS; i++)
        begin
            pg = {1'b0, word, cpba_pkg::BIT_W'(i)};
            if (pg >= range_start && pg < range_end)
            begin
                wdata[i] = set;
            end
            else
            begin
                wdata[i] = rdata[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/contiguous_page_bitmap_allocator.sv -----
// contiguous_page_bitmap_allocator: first-fit contiguous page allocator, top level
// depends on cpba_pkg, cpba_ram, cpba_scan, cpba_mark
// flow: allocate scans window words, then marks the words of the found run, or ends after
//   the scan if no run fits; free marks the touched words; zero count or empty window skip both
// throughput: one item at a time; the next one is taken once its result is registered
// reset: async, clears control; then a clearing pass zeroes the bitmap ram, one word
//   a cycle, input stalled meanwhile
`default_nettype none

module contiguous_page_bitmap_allocator #(
    parameter int NUM_PAGES = 4096
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // request channel
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               mode,
    input  wire  [cpba_pkg::CNT_W-1:0]        page_count,
    input  wire  [cpba_pkg::FP_W-1:0]         free_start,
    // result channel
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic                              success,
    output logic [cpba_pkg::FP_W-1:0]         run_start,
    // configuration write channel
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [cpba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [cpba_pkg::CNT_W-1:0]        cfg_data
);

    // only pages below 8192 are ever touched, so the ram stops at 256 words
    localparam int NUM_WORDS = (NUM_PAGES + cpba_pkg::WORD_BITS - 1) / cpba_pkg::WORD_BITS;
    localparam int MAX_WORDS = 1 << cpba_pkg::WIDX_W;
    localparam int MEM_WORDS = NUM_WORDS > MAX_WORDS ? MAX_WORDS
                             : (NUM_WORDS < 2 ? 2 : NUM_WORDS);
    localparam int AW        = $clog2(MEM_WORDS);
    // allocation window cap and free clip point
    localparam int LIM_CAP   = NUM_PAGES < 4096 ? NUM_PAGES : 4096;
    localparam int FREE_CAP  = NUM_PAGES < 8192 ? NUM_PAGES : 8192;

    // controller state
    cpba_pkg::state_t                  state_reg, state_next;
    logic [AW-1:0]                     clr_reg, clr_next;

    // word pipeline: issue counter, last word, read-data valid and its word index
    logic [cpba_pkg::ISS_W-1:0]        iss_reg, iss_next;
    logic [cpba_pkg::ISS_W-1:0]        last_reg, last_next;
    logic                              dv_reg, dv_next;
    logic [cpba_pkg::WIDX_W-1:0]       wd_reg, wd_next;

    // request and mark range
    logic [cpba_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [cpba_pkg::PAGE_W-1:0]       ms_reg, ms_next;
    logic [cpba_pkg::PAGE_W-1:0]       me_reg, me_next;
    logic                              set_reg, set_next;

    // pending result of the item at work
    logic                              res_ok_reg, res_ok_next;
    logic [cpba_pkg::FP_W-1:0]         res_start_reg, res_start_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic                              success_reg, success_next;
    logic [cpba_pkg::FP_W-1:0]         run_start_reg, run_start_next;

    // configuration
    logic [cpba_pkg::FP_W-1:0]         fp_reg, fp_next;
    logic [cpba_pkg::CNT_W-1:0]        lim_reg, lim_next;

    // ram ports
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [cpba_pkg::WORD_BITS-1:0]    ram_wdata;
    logic                              ram_re;
    logic [cpba_pkg::WORD_BITS-1:0]    ram_rdata;
    logic [cpba_pkg::WORD_BITS-1:0]    mark_wdata;

    // scan unit
    cpba_pkg::scan_ctl_t               scan_ctl;
    cpba_pkg::scan_res_t               scan_res;

    // derived values
    logic [cpba_pkg::CNT_W-1:0]        lim_eff;
    logic [cpba_pkg::CNT_W-1:0]        lim_m1;
    logic [cpba_pkg::PAGE_W-1:0]       free_end;
    logic [cpba_pkg::PAGE_W-1:0]       free_clip;
    logic [cpba_pkg::PAGE_W-1:0]       free_m1;
    logic [cpba_pkg::PAGE_W-1:0]       hit_end;
    logic [cpba_pkg::PAGE_W-1:0]       hit_m1;
    logic                              issue;
    logic                              out_free;

    cpba_ram #(
        .WIDTH (cpba_pkg::WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (iss_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    cpba_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .rdata      (ram_rdata),
        .word       (wd_reg),
        .first_page (fp_reg),
        .lim        (lim_eff),
        .count      (cnt_reg),
        .res        (scan_res)
    );

    cpba_mark u_mark (
        .rdata       (ram_rdata),
        .word        (wd_reg),
        .range_start (ms_reg),
        .range_end   (me_reg),
        .set         (set_reg),
        .wdata       (mark_wdata)
    );

    // limits above the bitmap act as the bitmap size
    assign lim_eff   = lim_reg > cpba_pkg::CNT_W'(LIM_CAP) ? cpba_pkg::CNT_W'(LIM_CAP)
                                                           : lim_reg;
    assign lim_m1    = lim_eff - 13'd1;
    // a free runs off the end of the bitmap silently
    assign free_end  = cpba_pkg::PAGE_W'(free_start) + cpba_pkg::PAGE_W'(page_count);
    assign free_clip = free_end > cpba_pkg::PAGE_W'(FREE_CAP) ? cpba_pkg::PAGE_W'(FREE_CAP)
                                                              : free_end;
    assign free_m1   = free_clip - 14'd1;
    assign hit_end   = scan_res.start + cpba_pkg::PAGE_W'(cnt_reg);
    assign hit_m1    = hit_end - 14'd1;

    // one word read per cycle while the issue counter has not passed the last word
    assign issue     = iss_reg <= last_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // ports
    assign in_stall  = state_reg != cpba_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign run_start = run_start_reg;
    assign cfg_ready = 1'b1;

    // configuration writes, taken in any state
    always_comb
    begin
        fp_next  = fp_reg;
        lim_next = lim_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cpba_pkg::CFG_FIRST_PAGE: fp_next  = cfg_data[cpba_pkg::FP_W-1:0];
                cpba_pkg::CFG_PAGE_LIMIT: lim_next = cfg_data;
                default:                  ;
            endcase
        end
    end

    // controller: next state, ram control and result handling
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        iss_next       = iss_reg;
        last_next      = last_reg;
        dv_next        = 1'b0;
        wd_next        = wd_reg;
        cnt_next       = cnt_reg;
        ms_next        = ms_reg;
        me_next        = me_reg;
        set_next       = set_reg;
        res_ok_next    = res_ok_reg;
        res_start_next = res_start_reg;
        out_valid_next = out_valid_reg && out_stall;
        success_next   = success_reg;
        run_start_next = run_start_reg;
        ram_we         = 1'b0;
        ram_waddr      = wd_reg[AW-1:0];
        ram_wdata      = mark_wdata;
        ram_re         = 1'b0;
        scan_ctl       = '0;

        case (state_reg)
            // zero the bitmap after reset
            cpba_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == AW'(MEM_WORDS - 1))
                begin
                    state_next = cpba_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            // take an item and set up the word range it works on
            cpba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = page_count;
                    if (mode == cpba_pkg::MODE_FREE)
                    begin
                        res_start_next = free_start;
                        if (page_count == '0)
                        begin
                            res_ok_next = 1'b0;
                            state_next  = cpba_pkg::ST_FINISH;
                        end
                        else if (cpba_pkg::PAGE_W'(free_start) >= cpba_pkg::PAGE_W'(FREE_CAP))
                        begin
                            // whole run lies past the bitmap
                            res_ok_next = 1'b1;
                            state_next  = cpba_pkg::ST_FINISH;
                        end
                        else
                        begin
                            res_ok_next = 1'b1;
                            ms_next     = cpba_pkg::PAGE_W'(free_start);
                            me_next     = free_clip;
                            set_next    = 1'b0;
                            iss_next    = cpba_pkg::ISS_W'(
                                              free_start[cpba_pkg::FP_W-1:cpba_pkg::BIT_W]);
                            last_next   = cpba_pkg::ISS_W'(
                                              free_m1[cpba_pkg::PAGE_W-1:cpba_pkg::BIT_W]);
                            state_next  = cpba_pkg::ST_MARK;
                        end
                    end
                    else
                    begin
                        res_ok_next    = 1'b0;
                        res_start_next = '0;
                        if (page_count == '0 || {1'b0, fp_reg} >= lim_eff)
                        begin
                            // zero count or empty window fails at once
                            state_next = cpba_pkg::ST_FINISH;
                        end
                        else
                        begin
                            scan_ctl.clear = 1'b1;
                            iss_next       = cpba_pkg::ISS_W'(
                                                 fp_reg[cpba_pkg::FP_W-1:cpba_pkg::BIT_W]);
                            last_next      = cpba_pkg::ISS_W'(
                                                 lim_m1[cpba_pkg::CNT_W-1:cpba_pkg::BIT_W]);
                            state_next     = cpba_pkg::ST_SCAN;
                        end
                    end
                end
            end

            // stream words through the scan unit, stop at the first fitting run
            cpba_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    ram_re   = 1'b1;
                    iss_next = iss_reg + 1'b1;
                    wd_next  = iss_reg[cpba_pkg::WIDX_W-1:0];
                    dv_next  = 1'b1;
                end
                if (dv_reg)
                begin
                    scan_ctl.step = 1'b1;
                    if (scan_res.hit)
                    begin
                        // in-flight read is dropped, marking restarts the pipeline
                        res_ok_next    = 1'b1;
                        res_start_next = scan_res.start[cpba_pkg::FP_W-1:0];
                        ms_next        = scan_res.start;
                        me_next        = hit_end;
                        set_next       = 1'b1;
                        iss_next       = cpba_pkg::ISS_W'(
                                             scan_res.start[cpba_pkg::PAGE_W-1:cpba_pkg::BIT_W]);
                        last_next      = cpba_pkg::ISS_W'(
                                             hit_m1[cpba_pkg::PAGE_W-1:cpba_pkg::BIT_W]);
                        dv_next        = 1'b0;
                        state_next     = cpba_pkg::ST_MARK;
                    end
                    else if (cpba_pkg::ISS_W'(wd_reg) == last_reg)
                    begin
                        // window exhausted, result stays failed
                        dv_next    = 1'b0;
                        state_next = cpba_pkg::ST_FINISH;
                    end
                end
            end

            // read-modify-write each word of the range; read of word k+1
            // overlaps the write of word k, so addresses never collide
            cpba_pkg::ST_MARK:
            begin
                if (issue)
                begin
                    ram_re   = 1'b1;
                    iss_next = iss_reg + 1'b1;
                    wd_next  = iss_reg[cpba_pkg::WIDX_W-1:0];
                    dv_next  = 1'b1;
                end
                if (dv_reg)
                begin
                    ram_we = 1'b1;
                    if (cpba_pkg::ISS_W'(wd_reg) == last_reg)
                    begin
                        dv_next    = 1'b0;
                        state_next = cpba_pkg::ST_FINISH;
                    end
                end
            end

            // hand the result to the output register once it has room
            cpba_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    success_next   = res_ok_reg;
                    run_start_next = res_start_reg;
                    state_next     = cpba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpba_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpba_pkg::ST_CLEAR;
            clr_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            fp_reg        <= '0;
            lim_reg       <= 13'd4096;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
            fp_reg        <= fp_next;
            lim_reg       <= lim_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        iss_reg       <= iss_next;
        last_reg      <= last_next;
        wd_reg        <= wd_next;
        cnt_reg       <= cnt_next;
        ms_reg        <= ms_next;
        me_reg        <= me_next;
        set_reg       <= set_next;
        res_ok_reg    <= res_ok_next;
        res_start_reg <= res_start_next;
        success_reg   <= success_next;
        run_start_reg <= run_start_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpba_checker.sv -----
// cpba_checker: port-level checks of the allocator's item flow, bound to the top level
// depends on cpba_pkg widths and contiguous_page_bitmap_allocator ports
`default_nettype none

module cpba_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_stall,
    input wire                         out_valid,
    input wire                         out_stall,
    input wire                         success,
    input wire [cpba_pkg::FP_W-1:0]    run_start
);

    // items accepted and not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(success) && $stable(run_start))
        else $error("result changed while stalled");

    // no result without an item behind it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result with no item pending");

    // at most one item at work plus one waiting result
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg != 2'd2)
        else $error("item taken while two are outstanding");

    // reset empties the output
    a_reset_out: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind contiguous_page_bitmap_allocator cpba_checker u_cpba_checker (.*);

`default_nettype wire

// ----- bench/contiguous_page_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps
// contiguous_page_bitmap_allocator_tb: self-checking bench for the first-fit page allocator
// holds a bitmap scoreboard that predicts every grant; random idle on both channels
// depends on cpba_pkg and contiguous_page_bitmap_allocator

module contiguous_page_bitmap_allocator_tb;

    import cpba_pkg::*;

    localparam int PAGES = 4096;

    // one predicted result: grant flag and first page of the run
    typedef struct packed {
        logic            ok;
        logic [FP_W-1:0] start;
    } grant_t;

    // a run handed out earlier, kept so that frees can hit real allocations
    typedef struct {
        int first;
        int cnt;
    } page_run_t;

    // bitmap predictor plus the queue of grants still owed by the block
    class page_map_scoreboard;
        bit [PAGES-1:0] used_map;
        bit [FP_W-1:0]  first_pg;
        bit [CNT_W-1:0] limit_pg;
        grant_t         grant_q[$];
        int             errors;
        int             reported;

        function new();
            used_map = '0;
            first_pg = '0;
            limit_pg = 13'd4096;
            errors   = 0;
            reported = 0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CNT_W-1:0] data);
            if (idx == CFG_FIRST_PAGE)
                first_pg = data[FP_W-1:0];
            else if (idx == CFG_PAGE_LIMIT)
                limit_pg = data;
        endfunction

        function grant_t note_request(bit req_mode, bit [CNT_W-1:0] req_count,
                                      bit [FP_W-1:0] req_start);
            grant_t g;
            int     lim;
            int     run_len;
            int     base;
            int     p;
            g.ok    = 1'b0;
            g.start = '0;
            base    = 0;
            if (req_mode == MODE_FREE)
            begin
                g.start = req_start;
                if (req_count != '0)
                begin
                    for (p = 0; p < int'(req_count); p++)
                        if (int'(req_start) + p < PAGES)
                            used_map[int'(req_start) + p] = 1'b0;
                    g.ok = 1'b1;
                end
            end
            else if (req_count != '0)
            begin
                // limits past the bitmap behave as the bitmap size
                lim     = (int'(limit_pg) > PAGES) ? PAGES : int'(limit_pg);
                run_len = 0;
                for (p = int'(first_pg); p < lim; p++)
                begin
                    if (used_map[p])
                        run_len = 0;
                    else
                        run_len++;
                    if (run_len == int'(req_count))
                    begin
                        base = p + 1 - int'(req_count);
                        g.ok = 1'b1;
                        break;
                    end
                end
                if (g.ok)
                begin
                    g.start = base[FP_W-1:0];
                    for (p = base; p < base + int'(req_count); p++)
                        used_map[p] = 1'b1;
                end
            end
            grant_q.push_back(g);
            return g;
        endfunction

        function void check_result(bit got_ok, bit [FP_W-1:0] got_start);
            grant_t g;
            if (grant_q.size() == 0)
            begin
                errors++;
                if (reported < 10)
                    $display("unexpected result: success %0d run_start %0d",
                             got_ok, got_start);
                reported++;
                return;
            end
            g = grant_q.pop_front();
            if (g.ok !== got_ok || g.start !== got_start)
            begin
                errors++;
                if (reported < 10)
                    $display({"mismatch: expected success %0d run_start %0d, ",
                              "got success %0d run_start %0d"},
                             g.ok, g.start, got_ok, got_start);
                reported++;
            end
        endfunction

        function int pending();
            return grant_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [CNT_W-1:0]     page_count;
    logic [FP_W-1:0]      free_start;
    logic                 out_valid;
    logic                 out_stall;
    logic                 success;
    logic [FP_W-1:0]      run_start;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    page_map_scoreboard   sb;
    page_run_t            live_runs[$];
    bit                   quiet;       // no idling on either side while set
    int                   stall_left;

    contiguous_page_bitmap_allocator #(
        .NUM_PAGES(PAGES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .page_count (page_count),
        .free_start (free_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .success    (success),
        .run_start  (run_start),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle length for the next item on either side
    function automatic int idle_cycles();
        if (quiet)
            return 0;
        return int'($urandom_range(0, 10));
    endfunction

    // result side: check every accepted item, then hold stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(success, run_start);
            stall_left = idle_cycles();
            out_stall <= (stall_left != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= (stall_left != 0);
        end
    end

    // one request item; valid stays high across back-to-back items
    task automatic send_request(bit req_mode, bit [CNT_W-1:0] req_count,
                                bit [FP_W-1:0] req_start);
        grant_t    g;
        page_run_t pr;
        int        gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= req_mode;
        page_count <= req_count;
        free_start <= req_start;
        do
            @(posedge clk);
        while (in_stall);
        g = sb.note_request(req_mode, req_count, req_start);
        // remember granted runs so later frees can return them
        if (req_mode == MODE_ALLOC && g.ok)
        begin
            pr.first = int'(g.start);
            pr.cnt   = int'(req_count);
            live_runs.push_back(pr);
        end
    endtask

    // both window registers, valid held high across the pair
    task automatic set_window(int first, int limit);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FIRST_PAGE;
        cfg_data  <= first[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(CFG_FIRST_PAGE, first[CNT_W-1:0]);
        cfg_index <= CFG_PAGE_LIMIT;
        cfg_data  <= limit[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(CFG_PAGE_LIMIT, limit[CNT_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and let every owed result come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // mostly small allocations and frees of live runs; some noise and oversized counts
    task automatic random_request();
        int             r;
        int             k;
        bit [CNT_W-1:0] cnt;
        bit [FP_W-1:0]  fs;
        page_run_t      pr;
        fs = FP_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 99) < 55)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 3)
                cnt = '0;
            else if (r < 80)
                cnt = CNT_W'($urandom_range(1, 16));
            else if (r < 95)
                cnt = CNT_W'($urandom_range(17, 256));
            else if (r < 98)
                cnt = CNT_W'($urandom_range(257, 4096));
            else
                cnt = CNT_W'($urandom_range(4097, 8191));
            send_request(MODE_ALLOC, cnt, fs);
        end
        else if (live_runs.size() > 0 && $urandom_range(0, 99) < 75)
        begin
            // give back a run handed out earlier
            k  = int'($urandom_range(0, live_runs.size() - 1));
            pr = live_runs[k];
            live_runs.delete(k);
            send_request(MODE_FREE, pr.cnt[CNT_W-1:0], pr.first[FP_W-1:0]);
        end
        else
        begin
            // stray free: never-allocated pages, zero count or running off the end
            r = int'($urandom_range(0, 99));
            if (r < 5)
                cnt = '0;
            else if (r < 88)
                cnt = CNT_W'($urandom_range(1, 32));
            else
                cnt = CNT_W'($urandom_range(33, 8191));
            send_request(MODE_FREE, cnt, fs);
        end
    endtask

    // window settings per phase; entries of -1 get random windows
    int win_first [10] = '{100,    0, 4095, 2000, 0, 37, -1, -1, -1, 0};
    int win_limit [10] = '{600, 5000, 4096, 1000, 0, 4096, -1, -1, -1, 4096};

    initial
    begin
        int first;
        int limit;
        sb         = new();
        quiet      = 1'b0;
        stall_left = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_ALLOC;
        page_count = '0;
        free_start = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_FIRST_PAGE;
        cfg_data   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset window: whole bitmap, zero counts, word edges, holes
        send_request(MODE_ALLOC, 13'd0, 12'h123);      // zero-page allocation fails
        send_request(MODE_FREE, 13'd0, 12'hfff);       // zero-page free echoes its start
        send_request(MODE_ALLOC, 13'd4096, 12'd0);     // whole bitmap in one run
        send_request(MODE_ALLOC, 13'd1, 12'd0);        // nothing left
        send_request(MODE_FREE, 13'd4096, 12'd0);
        send_request(MODE_ALLOC, 13'd1, 12'hfff);
        send_request(MODE_ALLOC, 13'd31, 12'd0);
        send_request(MODE_ALLOC, 13'd33, 12'd0);       // crosses a word boundary
        send_request(MODE_ALLOC, 13'd8191, 12'd0);     // larger than the window
        send_request(MODE_FREE, 13'd8191, 12'd4090);   // runs off the end of the bitmap
        send_request(MODE_FREE, 13'd5, 12'd3000);      // pages never handed out
        send_request(MODE_ALLOC, 13'd100, 12'h555);
        send_request(MODE_FREE, 13'd10, 12'd80);       // punch a hole in the middle
        send_request(MODE_ALLOC, 13'd10, 12'd0);       // first fit lands in the hole
        send_request(MODE_ALLOC, 13'd11, 12'd0);       // too big for any hole
        send_request(MODE_FREE, 13'd1, 12'd0);
        send_request(MODE_ALLOC, 13'd2, 12'd0);
        send_request(MODE_FREE, 13'd8191, 12'd0);      // clear everything
        send_request(MODE_ALLOC, 13'd4095, 12'haaa);
        send_request(MODE_ALLOC, 13'd2, 12'd0);        // one page left, two asked
        send_request(MODE_ALLOC, 13'd1, 12'd0);        // top page of the bitmap
        send_request(MODE_FREE, 13'd4096, 12'd0);
        drain();
        live_runs.delete();

        // random phases, each under its own window
        for (int ph = 0; ph < 10; ph++)
        begin
            first = win_first[ph];
            limit = win_limit[ph];
            if (first < 0)
            begin
                first = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 255))
                                                    : int'($urandom_range(0, 4095));
                limit = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8191))
                                                    : int'($urandom_range(first, 4096));
            end
            set_window(first, limit);
            for (int i = 0; i < 50; i++)
            begin
                // stretches with no idling now and then
                if (i % 25 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                random_request();
            end
            drain();
        end

        // wait out the owed results, then a margin for anything stray
        quiet = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

endmodule
